// ----- rtl/mseu_pkg.sv -----
// Shared types, constants and helper functions for the execute unit.
package mseu_pkg;

    localparam int DATA_W      = 32;
    localparam int REG_COUNT   = 18;
    localparam int REG_IDX_W   = 5;
    localparam int KIND_W      = 3;
    localparam int STATUS_W    = 2;
    localparam int S_REG_COUNT = 8;
    localparam int T_REG_COUNT = 10;
    localparam int S_IDX_W     = $clog2(S_REG_COUNT);
    localparam int T_IDX_W     = $clog2(T_REG_COUNT);
    localparam int MD_CNT_W    = $clog2(DATA_W);

    // Instruction kinds as they arrive on the input channel.
    typedef enum logic [KIND_W-1:0] {
        K_ADD,
        K_SUB,
        K_MUL,
        K_DIV,
        K_REM,
        K_ADDU,
        K_ADDI,
        K_JR
    } t_kind;

    // Completion status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_DIV_ZERO,
        ST_BAD_JR
    } t_status;

    // Top-level sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_RD1,
        S_RD2,
        S_EXEC,
        S_WAIT,
        S_DONE
    } t_seq_state;

    // Multiply/divide unit states.
    typedef enum logic [1:0] {
        MD_IDLE,
        MD_RUN,
        MD_FIX
    } t_md_state;

    // Operations of the multiply/divide unit.
    typedef enum logic [1:0] {
        MD_MUL,
        MD_DIV,
        MD_REM
    } t_md_op;

    // Request from the sequencer to the multiply/divide unit.
    typedef struct packed {
        logic   start;
        t_md_op op;
    } t_md_req;

    // Power-up contents of the s and t registers.
    localparam logic [DATA_W-1:0] S_RESET_VALS [S_REG_COUNT] = '{
        32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd7
    };
    localparam logic [DATA_W-1:0] T_RESET_VALS [T_REG_COUNT] = '{
        32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd7, 32'd8, 32'd9
    };

    // Value an entry holds before its first write.
    function automatic logic [DATA_W-1:0] f_reset_val(input logic [REG_IDX_W-1:0] idx);
        logic [REG_IDX_W-1:0] t_idx;
        logic [DATA_W-1:0]    val;
        t_idx = idx - REG_IDX_W'(S_REG_COUNT);
        if (idx < REG_IDX_W'(S_REG_COUNT)) begin
            val = S_RESET_VALS[idx[S_IDX_W-1:0]];
        end else if (t_idx < REG_IDX_W'(T_REG_COUNT)) begin
            val = T_RESET_VALS[t_idx[T_IDX_W-1:0]];
        end else begin
            val = '0;
        end
        return val;
    endfunction

endpackage

// ----- rtl/mseu_if.sv -----
// Valid/ready channel interfaces for instructions and results.
interface mseu_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [mseu_pkg::KIND_W-1:0]          kind;
    logic [mseu_pkg::REG_IDX_W-1:0]       dest_reg;
    logic [mseu_pkg::REG_IDX_W-1:0]       src1_reg;
    logic [mseu_pkg::REG_IDX_W-1:0]       src2_reg;
    logic signed [mseu_pkg::DATA_W-1:0]   immediate;

    modport source (output valid, kind, dest_reg, src1_reg, src2_reg, immediate,
                    input ready);
    modport sink   (input valid, kind, dest_reg, src1_reg, src2_reg, immediate,
                    output ready);
endinterface

interface mseu_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [mseu_pkg::DATA_W-1:0]   result_value;
    logic                                 wrote_register;
    logic [mseu_pkg::STATUS_W-1:0]        status;
    logic signed [mseu_pkg::DATA_W-1:0]   stack_pointer_out;

    modport source (output valid, result_value, wrote_register, status, stack_pointer_out,
                    input ready);
    modport sink   (input valid, result_value, wrote_register, status, stack_pointer_out,
                    output ready);
endinterface

// ----- rtl/mips_subset_execute_unit.sv -----
// Top level: sequencer, register file and stack pointer of the execute unit.
//
//  Channel   Dir  Fields                                                Transfer
//  i_in      in   kind, dest_reg, src1_reg, src2_reg, immediate         valid & ready
//  o_out     out  result_value, wrote_register, status, stack_pointer   valid & ready
//
// An ADD, SUB, ADDU, ADDI or JR goes from transfer through RD1, RD2, EXEC and DONE
// to a loaded result; a divide or remainder by zero takes the same path.
// MUL, DIV and REM also pass through WAIT: the shared multiply/divide unit iterates one
// bit per cycle over all 32 bits, then applies sign correction in its FIX state.
// One instruction is in flight at a time; i_in.ready is high only when idle.
// A finished result waits in the output register; the next instruction is
// accepted meanwhile and stalls only at its own completion if that slot is full.
// Reset is synchronous and active low; register contents take their reset values
// from per-entry valid bits, so no clearing pass is needed.
module mips_subset_execute_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mseu_in_if.sink           i_in,
    mseu_out_if.source        o_out
);

    localparam int DW = mseu_pkg::DATA_W;
    localparam int IW = mseu_pkg::REG_IDX_W;

    mseu_pkg::t_seq_state r_state;
    mseu_pkg::t_seq_state n_state;

    mseu_pkg::t_kind      r_kind;
    logic [IW-1:0]        r_dest;
    logic [IW-1:0]        r_src1;
    logic [IW-1:0]        r_src2;
    logic [DW-1:0]        r_imm;
    logic [DW-1:0]        r_a;
    logic [DW-1:0]        r_b;
    logic [DW-1:0]        r_value;
    logic                 r_do_write;
    mseu_pkg::t_status    r_status;
    logic [DW-1:0]        r_sp;
    logic [mseu_pkg::REG_COUNT-1:0] r_valid;

    logic                 r_out_valid;
    logic [DW-1:0]        r_out_value;
    logic                 r_out_wrote;
    mseu_pkg::t_status    r_out_status;
    logic [DW-1:0]        r_out_sp;

    logic [DW-1:0]        n_value;
    logic                 n_do_write;
    mseu_pkg::t_status    n_status;
    logic [DW-1:0]        n_sp;

    logic                 w_accept;
    logic                 w_slot_free;
    logic                 w_dest_ok;
    logic                 w_b_zero;
    logic                 w_use_md;
    logic [IW-1:0]        w_raddr;
    logic [DW-1:0]        w_rdata;
    logic [IW-1:0]        w_rd_idx;
    logic [DW-1:0]        w_rd_val;
    logic                 w_ram_we;
    logic [DW-1:0]        w_add_b;
    logic                 w_sub;
    logic [DW-1:0]        w_add;
    mseu_pkg::t_md_req    w_md_req;
    logic                 w_md_done;
    logic [DW-1:0]        w_md_result;

    // Handshake and status conditions.
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_slot_free = !r_out_valid || o_out.ready;
    assign w_dest_ok   = (r_dest < IW'(mseu_pkg::REG_COUNT));
    assign w_b_zero    = (r_b == '0);
    assign w_use_md    = (r_kind == mseu_pkg::K_MUL) ||
                         (((r_kind == mseu_pkg::K_DIV) || (r_kind == mseu_pkg::K_REM))
                          && !w_b_zero);

    // Register file storage; the read address is the first source while idle.
    assign w_raddr  = (r_state == mseu_pkg::S_IDLE) ? i_in.src1_reg : r_src2;
    assign w_ram_we = (r_state == mseu_pkg::S_DONE) && w_slot_free && r_do_write && w_dest_ok;

    mseu_ram #(
        .WIDTH (DW),
        .DEPTH (mseu_pkg::REG_COUNT)
    ) u_regfile (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_dest),
        .i_wdata (r_value),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Read value with reset-value fallback; out-of-range sources read as zero.
    always_comb begin
        w_rd_idx = (r_state == mseu_pkg::S_RD1) ? r_src1 : r_src2;
        if (w_rd_idx >= IW'(mseu_pkg::REG_COUNT)) begin
            w_rd_val = '0;
        end else if (r_valid[w_rd_idx]) begin
            w_rd_val = w_rdata;
        end else begin
            w_rd_val = mseu_pkg::f_reset_val(w_rd_idx);
        end
    end

    // Single adder for ADD, SUB, ADDU and ADDI.
    assign w_sub   = (r_kind == mseu_pkg::K_SUB);
    assign w_add_b = w_sub ? ~r_b : ((r_kind == mseu_pkg::K_ADDI) ? r_imm : r_b);
    assign w_add   = r_a + w_add_b + DW'(w_sub);

    // Shared multiply/divide unit.
    always_comb begin
        w_md_req.start = (r_state == mseu_pkg::S_EXEC) && w_use_md;
        case (r_kind)
            mseu_pkg::K_DIV: w_md_req.op = mseu_pkg::MD_DIV;
            mseu_pkg::K_REM: w_md_req.op = mseu_pkg::MD_REM;
            default:         w_md_req.op = mseu_pkg::MD_MUL;
        endcase
    end

    mseu_muldiv u_muldiv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_md_req),
        .i_a      (r_a),
        .i_b      (r_b),
        .o_done   (w_md_done),
        .o_result (w_md_result)
    );

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            mseu_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = mseu_pkg::S_RD1;
                end
            end
            mseu_pkg::S_RD1: n_state = mseu_pkg::S_RD2;
            mseu_pkg::S_RD2: n_state = mseu_pkg::S_EXEC;
            mseu_pkg::S_EXEC: begin
                n_state = w_use_md ? mseu_pkg::S_WAIT : mseu_pkg::S_DONE;
            end
            mseu_pkg::S_WAIT: begin
                if (w_md_done) begin
                    n_state = mseu_pkg::S_DONE;
                end
            end
            mseu_pkg::S_DONE: begin
                if (w_slot_free) begin
                    n_state = mseu_pkg::S_IDLE;
                end
            end
            default: n_state = mseu_pkg::S_IDLE;
        endcase
    end

    // Outputs of the sequencer: result, write enable, status and stack pointer.
    always_comb begin
        n_value    = r_value;
        n_do_write = r_do_write;
        n_status   = r_status;
        n_sp       = r_sp;
        case (r_state)
            mseu_pkg::S_EXEC: begin
                n_value    = '0;
                n_do_write = 1'b1;
                n_status   = mseu_pkg::ST_OK;
                case (r_kind)
                    mseu_pkg::K_ADD, mseu_pkg::K_SUB, mseu_pkg::K_ADDU,
                    mseu_pkg::K_ADDI: begin
                        n_value = w_add;
                    end
                    mseu_pkg::K_DIV, mseu_pkg::K_REM: begin
                        if (w_b_zero) begin
                            n_do_write = 1'b0;
                            n_status   = mseu_pkg::ST_DIV_ZERO;
                        end
                    end
                    mseu_pkg::K_JR: begin
                        n_do_write = 1'b0;
                        if (w_dest_ok) begin
                            n_sp    = r_b;
                            n_value = r_b;
                        end else begin
                            n_status = mseu_pkg::ST_BAD_JR;
                        end
                    end
                    default: begin
                        n_value = '0;
                    end
                endcase
            end
            mseu_pkg::S_WAIT: begin
                if (w_md_done) begin
                    n_value = w_md_result;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    assign i_in.ready = (r_state == mseu_pkg::S_IDLE);

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mseu_pkg::S_IDLE;
            r_valid     <= '0;
            r_sp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sp    <= n_sp;
            if (w_ram_we) begin
                r_valid[r_dest] <= 1'b1;
            end
            if (r_state == mseu_pkg::S_DONE && w_slot_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind <= mseu_pkg::t_kind'(i_in.kind);
            r_dest <= i_in.dest_reg;
            r_src1 <= i_in.src1_reg;
            // A jump reads its register through the second read slot.
            r_src2 <= (mseu_pkg::t_kind'(i_in.kind) == mseu_pkg::K_JR) ? i_in.dest_reg
                                                                        : i_in.src2_reg;
            r_imm  <= i_in.immediate;
        end
        if (r_state == mseu_pkg::S_RD1) begin
            r_a <= w_rd_val;
        end
        if (r_state == mseu_pkg::S_RD2) begin
            r_b <= w_rd_val;
        end
        r_value    <= n_value;
        r_do_write <= n_do_write;
        r_status   <= n_status;
        if (r_state == mseu_pkg::S_DONE && w_slot_free) begin
            r_out_value  <= r_value;
            r_out_wrote  <= r_do_write && w_dest_ok;
            r_out_status <= r_status;
            r_out_sp     <= r_sp;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.result_value      = r_out_value;
    assign o_out.wrote_register    = r_out_wrote;
    assign o_out.status            = r_out_status;
    assign o_out.stack_pointer_out = r_out_sp;

`ifndef SYNTHESIS
    // The register file is written only when a result is handed to the output.
    a_write_at_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_we |-> (r_state == mseu_pkg::S_DONE) && w_dest_ok)
        else $error("register file written outside completion");

    // The multiply/divide unit finishes only while the sequencer waits for it.
    a_md_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_md_done |-> (r_state == mseu_pkg::S_WAIT))
        else $error("multiply/divide result arrived unexpectedly");

    // A divide by zero never reports a register write.
    a_div_zero_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == mseu_pkg::ST_DIV_ZERO)) |-> !r_out_wrote)
        else $error("divide by zero reported a write");

    // The stack pointer changes only on execution of a jump.
    a_sp_only_jr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_sp)) |->
            ($past(r_state) == mseu_pkg::S_EXEC) && ($past(r_kind) == mseu_pkg::K_JR))
        else $error("stack pointer changed outside a jump");
`endif

endmodule

// ----- rtl/mseu_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module mseu_ram #(
    parameter int WIDTH = mseu_pkg::DATA_W,
    parameter int DEPTH = mseu_pkg::REG_COUNT,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/mseu_muldiv.sv -----
// Iterative shift-add multiplier and restoring divider sharing one adder.
module mseu_muldiv (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mseu_pkg::t_md_req             i_req,
    input  logic [mseu_pkg::DATA_W-1:0]   i_a,
    input  logic [mseu_pkg::DATA_W-1:0]   i_b,
    output logic                          o_done,
    output logic [mseu_pkg::DATA_W-1:0]   o_result
);

    localparam int DW    = mseu_pkg::DATA_W;
    localparam int CNT_W = mseu_pkg::MD_CNT_W;

    mseu_pkg::t_md_state r_state;
    mseu_pkg::t_md_state n_state;
    mseu_pkg::t_md_op    r_op;
    logic [CNT_W-1:0]    r_cnt;
    logic [DW-1:0]       r_acc;
    logic [DW-1:0]       r_x;
    logic [DW-1:0]       r_y;
    logic                r_neg;

    logic [DW-1:0]       w_a_mag;
    logic [DW-1:0]       w_b_mag;
    logic                w_is_div;
    logic [DW:0]         w_shift;
    logic [DW:0]         w_opa;
    logic [DW:0]         w_opb;
    logic [DW:0]         w_sum;
    logic                w_fit;
    logic [DW-1:0]       w_pick;

    // Operand magnitudes for the divider.
    assign w_a_mag = i_a[DW-1] ? (DW'(0) - i_a) : i_a;
    assign w_b_mag = i_b[DW-1] ? (DW'(0) - i_b) : i_b;

    // Shared adder: accumulate for multiply, trial subtract for divide.
    assign w_is_div = (r_op != mseu_pkg::MD_MUL);
    assign w_shift  = {r_acc, r_x[DW-1]};
    assign w_opa    = w_is_div ? w_shift : {1'b0, r_acc};
    assign w_opb    = w_is_div ? ~{1'b0, r_y} : {1'b0, (r_y[0] ? r_x : DW'(0))};
    assign w_sum    = w_opa + w_opb + (DW+1)'(w_is_div);
    assign w_fit    = ~w_sum[DW];

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            mseu_pkg::MD_IDLE: begin
                if (i_req.start) begin
                    n_state = mseu_pkg::MD_RUN;
                end
            end
            mseu_pkg::MD_RUN: begin
                if (r_cnt == CNT_W'(DW - 1)) begin
                    n_state = mseu_pkg::MD_FIX;
                end
            end
            mseu_pkg::MD_FIX: begin
                n_state = mseu_pkg::MD_IDLE;
            end
            default: begin
                n_state = mseu_pkg::MD_IDLE;
            end
        endcase
    end

    // Outputs: the result is presented, sign-corrected, in the final state.
    always_comb begin
        w_pick   = (r_op == mseu_pkg::MD_DIV) ? r_x : r_acc;
        o_done   = (r_state == mseu_pkg::MD_FIX);
        o_result = r_neg ? (DW'(0) - w_pick) : w_pick;
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mseu_pkg::MD_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            mseu_pkg::MD_IDLE: begin
                r_cnt <= '0;
                r_acc <= '0;
                r_op  <= i_req.op;
                if (i_req.op == mseu_pkg::MD_MUL) begin
                    r_x   <= i_a;
                    r_y   <= i_b;
                    r_neg <= 1'b0;
                end else begin
                    r_x   <= w_a_mag;
                    r_y   <= w_b_mag;
                    r_neg <= (i_req.op == mseu_pkg::MD_DIV) ? (i_a[DW-1] ^ i_b[DW-1])
                                                            : i_a[DW-1];
                end
            end
            mseu_pkg::MD_RUN: begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (w_is_div) begin
                    r_acc <= w_fit ? w_sum[DW-1:0] : w_shift[DW-1:0];
                    r_x   <= {r_x[DW-2:0], w_fit};
                end else begin
                    r_acc <= w_sum[DW-1:0];
                    r_x   <= {r_x[DW-2:0], 1'b0};
                    r_y   <= {1'b0, r_y[DW-1:1]};
                end
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the execute unit: directed table, random traffic, predictor.
module tb;
    import mseu_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int          HOLD_CYCLES = 400;
    localparam int          PHASE_ITEMS = 600;

    // One instruction as presented on the input channel.
    typedef struct packed {
        t_kind                kind;
        logic [REG_IDX_W-1:0] dest;
        logic [REG_IDX_W-1:0] src1;
        logic [REG_IDX_W-1:0] src2;
        logic [DATA_W-1:0]    imm;
    } t_instr;

    // One completed instruction as seen on the output channel.
    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              wrote;
        t_status           status;
        logic [DATA_W-1:0] sp;
    } t_outcome;

    // Directed stimulus row; the outcome is used only where it is typed in.
    typedef struct packed {
        t_instr   ins;
        logic     typed;
        t_outcome want;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    mseu_in_if  in_bus();
    mseu_out_if out_bus();

    mips_subset_execute_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    // Architectural state as the predictor sees it.
    logic [DATA_W-1:0] arch_regs [REG_COUNT];
    logic [DATA_W-1:0] arch_sp;

    t_outcome    pending_outcomes [$];
    t_dir_row    directed_rows [$];
    int          error_count = 0;
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          rx_hold_req;
    int unsigned cycle_count;

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Print one line per mismatch and count it.
    task automatic note_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        error_count++;
    endtask

    // Execute one instruction against the predictor state and return its outcome.
    function automatic t_outcome execute_instr(input t_instr ins);
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        longint            num;
        longint            den;
        t_outcome          res;
        bit                store;
        a     = (ins.src1 < REG_COUNT) ? arch_regs[ins.src1] : '0;
        b     = (ins.src2 < REG_COUNT) ? arch_regs[ins.src2] : '0;
        res   = '0;
        store = 1'b1;
        case (ins.kind)
            K_ADD, K_ADDU: res.value = a + b;
            K_SUB:         res.value = a - b;
            K_MUL:         res.value = a * b;
            K_DIV, K_REM: begin
                if (b == '0) begin
                    res.status = ST_DIV_ZERO;
                    store      = 1'b0;
                end else begin
                    // 64-bit math keeps the most negative over minus one well defined.
                    num = $signed(a);
                    den = $signed(b);
                    res.value = (ins.kind == K_DIV) ? 32'(num / den) : 32'(num % den);
                end
            end
            K_ADDI:        res.value = a + ins.imm;
            default: begin
                // Jump register: loads the stack pointer, never writes the file.
                store = 1'b0;
                if (ins.dest < REG_COUNT) begin
                    arch_sp   = arch_regs[ins.dest];
                    res.value = arch_sp;
                end else begin
                    res.status = ST_BAD_JR;
                end
            end
        endcase
        if (store && ins.dest < REG_COUNT) begin
            arch_regs[ins.dest] = res.value;
            res.wrote           = 1'b1;
        end
        res.sp = arch_sp;
        return res;
    endfunction

    // Random instruction; registers outside the file and extreme immediates show up often.
    function automatic t_instr random_instr();
        t_instr ins;
        ins.kind = t_kind'($urandom_range(0, 7));
        ins.dest = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(18, 31))
                                               : 5'($urandom_range(0, 17));
        ins.src1 = ($urandom_range(0, 11) == 0) ? 5'($urandom_range(18, 31))
                                                : 5'($urandom_range(0, 17));
        ins.src2 = ($urandom_range(0, 11) == 0) ? 5'($urandom_range(18, 31))
                                                : 5'($urandom_range(0, 17));
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 3))
                    0:       ins.imm = 32'h8000_0000;
                    1:       ins.imm = 32'h7FFF_FFFF;
                    2:       ins.imm = 32'hFFFF_FFFF;
                    default: ins.imm = 32'h0000_0000;
                endcase
            end
            1, 2:    ins.imm = 32'($urandom_range(0, 32)) - 32'd16;
            default: ins.imm = $urandom;
        endcase
        return ins;
    endfunction

    task automatic add_row(input t_kind k, input logic [4:0] d, input logic [4:0] s1,
                           input logic [4:0] s2, input logic [31:0] imm, input logic typed,
                           input logic [31:0] val, input logic wr, input t_status st,
                           input logic [31:0] sp);
        t_dir_row row;
        row.ins   = '{kind: k, dest: d, src1: s1, src2: s2, imm: imm};
        row.typed = typed;
        row.want  = '{value: val, wrote: wr, status: st, sp: sp};
        directed_rows.push_back(row);
    endtask

    // Offer one instruction, wait for its transfer, then record what it should produce.
    task automatic send_instr(input t_instr ins, input bit typed, input t_outcome typed_want);
        t_outcome predicted;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_bus.valid     <= 1'b1;
        in_bus.kind      <= ins.kind;
        in_bus.dest_reg  <= ins.dest;
        in_bus.src1_reg  <= ins.src1;
        in_bus.src2_reg  <= ins.src2;
        in_bus.immediate <= ins.imm;
        do @(posedge i_clk); while (!(in_bus.valid === 1'b1 && in_bus.ready === 1'b1));
        predicted = execute_instr(ins);
        pending_outcomes.push_back(typed ? typed_want : predicted);
    endtask

    // Stop offering and wait until every outstanding result has come back.
    task automatic wait_drained();
        in_bus.valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
    endtask

    // Compare one output transfer with the oldest expectation.
    task automatic check_outcome();
        t_outcome want;
        if (pending_outcomes.size() == 0) begin
            note_mismatch($sformatf("result with nothing pending, value %h",
                                    out_bus.result_value));
        end else begin
            want = pending_outcomes.pop_front();
            if (out_bus.result_value !== want.value)
                note_mismatch($sformatf("result_value got %h want %h",
                                        out_bus.result_value, want.value));
            if (out_bus.wrote_register !== want.wrote)
                note_mismatch($sformatf("wrote_register got %b want %b",
                                        out_bus.wrote_register, want.wrote));
            if (out_bus.status !== want.status)
                note_mismatch($sformatf("status got %0d want %s",
                                        out_bus.status, want.status.name()));
            if (out_bus.stack_pointer_out !== want.sp)
                note_mismatch($sformatf("stack_pointer_out got %h want %h",
                                        out_bus.stack_pointer_out, want.sp));
        end
    endtask

    // Result side: check every transfer and drive ready, with a single long hold-off.
    initial begin : result_side
        int hold_left;
        bit hold_taken;
        hold_left  = 0;
        hold_taken = 1'b0;
        out_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_bus.valid === 1'b1 && out_bus.ready === 1'b1) check_outcome();
            // The hold-off request is taken once; the stimulus side only ever raises it.
            if (rx_hold_req && !hold_taken) begin
                hold_left  = HOLD_CYCLES;
                hold_taken = 1'b1;
            end
            if (!i_rst_n) begin
                out_bus.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                out_bus.ready <= 1'b0;
            end else begin
                out_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog on the total run length.
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // Main sequence: reset, directed table, then three random phases.
    initial begin : stimulus
        int i;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rx_hold_req   = 1'b0;
        i_rst_n          <= 1'b0;
        in_bus.valid     <= 1'b0;
        in_bus.kind      <= K_ADD;
        in_bus.dest_reg  <= '0;
        in_bus.src1_reg  <= '0;
        in_bus.src2_reg  <= '0;
        in_bus.immediate <= '0;

        // Predictor state after reset.
        for (i = 0; i < S_REG_COUNT; i++) arch_regs[i] = DATA_W'(i);
        for (i = 0; i < T_REG_COUNT; i++) arch_regs[S_REG_COUNT + i] = DATA_W'(i);
        arch_sp = '0;

        // Directed table, walked in order; rows with typed = 0 go to the predictor.
        add_row(K_ADD,  0,  1,  2, 32'h0,         1, 32'h3,         1, ST_OK,       32'h0);
        add_row(K_SUB,  18, 2,  5, 32'h0,         1, 32'hFFFF_FFFD, 0, ST_OK,       32'h0);
        add_row(K_ADDI, 1,  8,  0, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 1, ST_OK,       32'h0);
        add_row(K_ADDI, 2,  8,  0, 32'h8000_0000, 1, 32'h8000_0000, 1, ST_OK,       32'h0);
        add_row(K_ADDU, 3,  1,  1, 32'h0,         1, 32'hFFFF_FFFE, 1, ST_OK,       32'h0);
        add_row(K_ADD,  4,  1,  9, 32'h0,         1, 32'h8000_0000, 1, ST_OK,       32'h0);
        add_row(K_MUL,  5,  1,  1, 32'h0,         0, 32'h0,         0, ST_OK,       32'h0);
        add_row(K_MUL,  6,  2,  3, 32'h0,         1, 32'h0,         1, ST_OK,       32'h0);
        // Divide and remainder by zero leave the destination alone.
        add_row(K_DIV,  7,  1,  8, 32'h0,         1, 32'h0,         0, ST_DIV_ZERO, 32'h0);
        add_row(K_REM,  7,  1,  6, 32'h0,         1, 32'h0,         0, ST_DIV_ZERO, 32'h0);
        add_row(K_SUB,  10, 8,  9, 32'h0,         1, 32'hFFFF_FFFF, 1, ST_OK,       32'h0);
        // Most negative over minus one wraps; its remainder is zero.
        add_row(K_DIV,  11, 2,  10, 32'h0,        1, 32'h8000_0000, 1, ST_OK,       32'h0);
        add_row(K_REM,  12, 2,  10, 32'h0,        1, 32'h0,         1, ST_OK,       32'h0);
        add_row(K_SUB,  15, 8,  7, 32'h0,         1, 32'hFFFF_FFF9, 1, ST_OK,       32'h0);
        add_row(K_DIV,  13, 15, 14, 32'h0,        0, 32'h0,         0, ST_OK,       32'h0);
        add_row(K_REM,  16, 15, 14, 32'h0,        0, 32'h0,         0, ST_OK,       32'h0);
        // Sources outside the file read as zero.
        add_row(K_ADD,  0,  31, 18, 32'h0,        1, 32'h0,         1, ST_OK,       32'h0);
        add_row(K_JR,   1,  0,  0, 32'h0,  1, 32'h7FFF_FFFF, 0, ST_OK,     32'h7FFF_FFFF);
        add_row(K_JR,   31, 0,  0, 32'h0,  1, 32'h0,         0, ST_BAD_JR, 32'h7FFF_FFFF);
        add_row(K_JR,   18, 0,  0, 32'h0,  1, 32'h0,         0, ST_BAD_JR, 32'h7FFF_FFFF);
        add_row(K_ADDI, 31, 17, 0, 32'hFFFF_FFF6, 1, 32'hFFFF_FFFF, 0, ST_OK, 32'h7FFF_FFFF);
        add_row(K_ADDI, 17, 17, 31, 32'h1,        1, 32'hA, 1, ST_OK,       32'h7FFF_FFFF);
        add_row(K_ADD,  8,  17, 9, 32'hFFFF_FFFF, 1, 32'hB, 1, ST_OK,       32'h7FFF_FFFF);
        add_row(K_JR,   2,  0,  0, 32'h0,  1, 32'h8000_0000, 0, ST_OK,     32'h8000_0000);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r])
            send_instr(directed_rows[r].ins, directed_rows[r].typed, directed_rows[r].want);
        wait_drained();

        // Sender mostly busy, receiver stalls often and starts with a long hold-off.
        send_idle_pct = 12;
        recv_idle_pct = 50;
        rx_hold_req   = 1'b1;
        repeat (PHASE_ITEMS) send_instr(random_instr(), 1'b0, '0);

        // Roles swapped, with a full pause half way through.
        send_idle_pct = 50;
        recv_idle_pct = 12;
        repeat (PHASE_ITEMS / 2) send_instr(random_instr(), 1'b0, '0);
        wait_drained();
        repeat (PHASE_ITEMS / 2) send_instr(random_instr(), 1'b0, '0);

        // Back to back on both sides.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (PHASE_ITEMS) send_instr(random_instr(), 1'b0, '0);

        wait_drained();
        repeat (50) @(posedge i_clk);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- mips_subset_execute_unit.f -----
rtl/mseu_pkg.sv
rtl/mseu_if.sv
rtl/mseu_ram.sv
rtl/mseu_muldiv.sv
rtl/mips_subset_execute_unit.sv
tb/sv/tb.sv
